FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the rotation matrix block, used by the top file.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only out of reset
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked only out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ezr_pkg.sv
// Package for the Euler x/y rotation matrix block: widths, constants, CORDIC
// arctangent table and the per-stage arithmetic functions. No dependencies.
`default_nettype none

package ezr_pkg;

  // Field formats
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int OUT_FRAC_BITS   = 15;
  localparam int CORDIC_STEPS    = 16;
  localparam int ANG_W           = 18;
  localparam int OUT_W           = 16;

  // Angle reduction in input units (two turns must cover the largest input magnitude)
  localparam int FULL_TURN_IN    = 360 << ANGLE_FRAC_BITS;
  localparam int HALF_TURN_IN    = FULL_TURN_IN / 2;
  localparam int QUARTER_TURN_IN = FULL_TURN_IN / 4;
  localparam int THREEQ_TURN_IN  = 3 * QUARTER_TURN_IN;
  localparam int MOD_W           = $clog2(FULL_TURN_IN);
  localparam int RED_W           = ANG_W + 2;

  // CORDIC angle: degrees with 16 fraction bits, room for the residual overshoot
  localparam int ZFRAC           = 16;
  localparam int ZSH             = ZFRAC - ANGLE_FRAC_BITS;
  localparam int Z_W             = 25;
  localparam logic signed [Z_W-1:0] QUARTER_Z = Z_W'(90 << ZFRAC);

  // CORDIC x/y: Q2.30 with one guard bit
  localparam int XY_FRAC         = 30;
  localparam int XY_W            = 33;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = XY_W'(652032874);

  // Products and output rounding
  localparam int MUL_W           = 32;
  localparam int PROD_W          = 2 * MUL_W;
  localparam int Q_W             = PROD_W + 2;
  localparam int RND_SH          = 2 * XY_FRAC - OUT_FRAC_BITS;
  localparam logic signed [Q_W-1:0] RND_HALF = Q_W'(1) <<< (RND_SH - 1);
  localparam logic signed [Q_W-1:0] OUT_MAX  = Q_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [Q_W-1:0] OUT_MIN  = -(Q_W'(1) <<< (OUT_W - 1));

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cord_t;

  typedef struct packed {
    logic signed [Z_W-1:0] z;
    logic                  neg;
  } fold_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m22;
  } mat_t;

  // round(atan(2^-i) in degrees * 2^16); zero from step 23 on
  function automatic logic signed [Z_W-1:0] atan_deg(input int unsigned i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:       a = Z_W'(2949120);
      1:       a = Z_W'(1740967);
      2:       a = Z_W'(919879);
      3:       a = Z_W'(466945);
      4:       a = Z_W'(234379);
      5:       a = Z_W'(117304);
      6:       a = Z_W'(58666);
      7:       a = Z_W'(29335);
      8:       a = Z_W'(14668);
      9:       a = Z_W'(7334);
      10:      a = Z_W'(3667);
      11:      a = Z_W'(1833);
      12:      a = Z_W'(917);
      13:      a = Z_W'(458);
      14:      a = Z_W'(229);
      15:      a = Z_W'(115);
      16:      a = Z_W'(57);
      17:      a = Z_W'(29);
      18:      a = Z_W'(14);
      19:      a = Z_W'(7);
      20:      a = Z_W'(4);
      21:      a = Z_W'(2);
      22:      a = Z_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  // Reduce an input angle into [0, 360) degrees
  function automatic logic [MOD_W-1:0] mod_turn(input logic signed [ANG_W-1:0] a);
    logic signed [RED_W-1:0] e;
    logic signed [RED_W-1:0] p1;
    logic signed [RED_W-1:0] p2;
    logic signed [RED_W-1:0] m1;
    logic signed [RED_W-1:0] r;
    e  = RED_W'(a);
    p1 = e + RED_W'(FULL_TURN_IN);
    p2 = e + RED_W'(2 * FULL_TURN_IN);
    m1 = e - RED_W'(FULL_TURN_IN);
    if (e < 0) begin
      r = (p1 < 0) ? p2 : p1;
    end else begin
      r = (e >= RED_W'(FULL_TURN_IN)) ? m1 : e;
    end
    return r[MOD_W-1:0];
  endfunction

  // Fold [0, 360) into [-90, 90], flag a half-turn shift, scale to CORDIC units
  function automatic fold_t fold_quarter(input logic [MOD_W-1:0] m);
    logic signed [MOD_W:0] ms;
    logic signed [MOD_W:0] d;
    fold_t                 f;
    ms    = signed'({1'b0, m});
    f.neg = 1'b0;
    if (ms <= (MOD_W + 1)'(QUARTER_TURN_IN)) begin
      d = ms;
    end else if (ms < (MOD_W + 1)'(THREEQ_TURN_IN)) begin
      d     = ms - (MOD_W + 1)'(HALF_TURN_IN);
      f.neg = 1'b1;
    end else begin
      d = ms - (MOD_W + 1)'(FULL_TURN_IN);
    end
    f.z = Z_W'(d) <<< ZSH;
    return f;
  endfunction

  // One rotation-mode CORDIC iteration
  function automatic cord_t cordic_step(input cord_t a, input int unsigned i);
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    cord_t                  r;
    x  = a.x;
    y  = a.y;
    z  = a.z;
    xs = x >>> i;
    ys = y >>> i;
    if (!z[Z_W-1]) begin
      r.x = x - ys;
      r.y = y + xs;
      r.z = z - atan_deg(i);
    end else begin
      r.x = x + ys;
      r.y = y - xs;
      r.z = z + atan_deg(i);
    end
    return r;
  endfunction

  // Q60 value rounded half up to the output format and saturated
  function automatic logic signed [OUT_W-1:0] q60_to_out(input logic signed [Q_W-1:0] v);
    logic signed [Q_W-1:0] t;
    logic signed [OUT_W-1:0] r;
    t = (v + RND_HALF) >>> RND_SH;
    if (t > OUT_MAX) begin
      r = OUT_MAX[OUT_W-1:0];
    end else if (t < OUT_MIN) begin
      r = OUT_MIN[OUT_W-1:0];
    end else begin
      r = t[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/euler_xy_rotation_matrix_top.sv
// Rotation matrix Rx(ax)*Ry(ay) from two angles in degrees, fully pipelined.
// Depends on ezr_pkg and assert_macros.svh.
//
//   channel | signals                              | dir | beat
//   --------+--------------------------------------+-----+---------------------------
//   in      | in_valid, in_ready, in_angle_{x,y}_deg | in  | one angle pair
//   out     | out_valid, out_ready, out_m00..m22    | out | one 3x3 matrix, Q1.15
//
// Registers in order: angle reduction, folding, the 16 unrolled CORDIC
// iterations (one register stage each, both angles in parallel lanes), the
// four 32x32 products, and rounding and saturation into the output register.
// One beat enters per cycle while in_ready is high. A stalled output holds its
// register; the stages behind it keep moving as long as the stage feeding the
// output is empty. rst_n is synchronous and clears the valid bits only.
`default_nettype none

module euler_xy_rotation_matrix_top
  import ezr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [ANG_W-1:0] in_angle_x_deg,
  input  wire logic signed [ANG_W-1:0] in_angle_y_deg,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [OUT_W-1:0]      out_m00,
  output logic signed [OUT_W-1:0]      out_m01,
  output logic signed [OUT_W-1:0]      out_m02,
  output logic signed [OUT_W-1:0]      out_m10,
  output logic signed [OUT_W-1:0]      out_m11,
  output logic signed [OUT_W-1:0]      out_m12,
  output logic signed [OUT_W-1:0]      out_m20,
  output logic signed [OUT_W-1:0]      out_m21,
  output logic signed [OUT_W-1:0]      out_m22
);

  `include "assert_macros.svh"

  // Pipeline control
  logic pipe_en;
  logic out_ld;

  // Reduction stage (lane 0 = x angle, lane 1 = y angle)
  logic                  v_mod_r;
  logic [MOD_W-1:0]      mod_r [2];

  // Fold stage
  logic                  v_fold_r;
  fold_t                 fold_r [2];

  // CORDIC stages
  logic [CORDIC_STEPS-1:0] v_cor_r;
  cord_t                   cor_r [CORDIC_STEPS][2];
  logic [1:0]              neg_r [CORDIC_STEPS];

  // Product stage
  logic                      v_mul_r;
  logic signed [MUL_W-1:0]   sx_r;
  logic signed [MUL_W-1:0]   cx_r;
  logic signed [MUL_W-1:0]   sy_r;
  logic signed [MUL_W-1:0]   cy_r;
  logic signed [PROD_W-1:0]  p_ss_r;
  logic signed [PROD_W-1:0]  p_sc_r;
  logic signed [PROD_W-1:0]  p_cs_r;
  logic signed [PROD_W-1:0]  p_cc_r;
  logic signed [MUL_W-1:0]   sx_nxt;
  logic signed [MUL_W-1:0]   cx_nxt;
  logic signed [MUL_W-1:0]   sy_nxt;
  logic signed [MUL_W-1:0]   cy_nxt;

  // Output register
  logic                  out_valid_r;
  mat_t                  out_r;
  mat_t                  out_nxt;

  // Advance all stages unless the output is stalled and a beat waits behind it
  assign out_ld   = !out_valid_r || out_ready;
  assign pipe_en  = out_ld || !v_mul_r;
  assign in_ready = pipe_en;

  // Reduce both angles modulo one turn
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_mod_r <= 1'b0;
    end else if (pipe_en) begin
      v_mod_r <= in_valid;
    end
    if (pipe_en) begin
      mod_r[0] <= mod_turn(in_angle_x_deg);
      mod_r[1] <= mod_turn(in_angle_y_deg);
    end
  end

  // Fold into a quarter turn either side of zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_fold_r <= 1'b0;
    end else if (pipe_en) begin
      v_fold_r <= v_mod_r;
    end
    if (pipe_en) begin
      fold_r[0] <= fold_quarter(mod_r[0]);
      fold_r[1] <= fold_quarter(mod_r[1]);
    end
  end

  // Unrolled CORDIC, one iteration per stage for both lanes
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cor
    cord_t      src [2];
    logic [1:0] neg_src;
    logic       v_src;

    if (i == 0) begin : g_first
      always_comb begin
        src[0]  = '{x: GAIN_Q30, y: '0, z: fold_r[0].z};
        src[1]  = '{x: GAIN_Q30, y: '0, z: fold_r[1].z};
        neg_src = {fold_r[1].neg, fold_r[0].neg};
        v_src   = v_fold_r;
      end
    end else begin : g_rest
      always_comb begin
        src[0]  = cor_r[i-1][0];
        src[1]  = cor_r[i-1][1];
        neg_src = neg_r[i-1];
        v_src   = v_cor_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_cor_r[i] <= 1'b0;
      end else if (pipe_en) begin
        v_cor_r[i] <= v_src;
      end
      if (pipe_en) begin
        cor_r[i][0] <= cordic_step(src[0], i);
        cor_r[i][1] <= cordic_step(src[1], i);
        neg_r[i]    <= neg_src;
      end
    end
  end

  // Undo the half-turn fold and narrow to multiplier width
  always_comb begin
    sx_nxt = MUL_W'(neg_r[CORDIC_STEPS-1][0] ? -cor_r[CORDIC_STEPS-1][0].y
                                             :  cor_r[CORDIC_STEPS-1][0].y);
    cx_nxt = MUL_W'(neg_r[CORDIC_STEPS-1][0] ? -cor_r[CORDIC_STEPS-1][0].x
                                             :  cor_r[CORDIC_STEPS-1][0].x);
    sy_nxt = MUL_W'(neg_r[CORDIC_STEPS-1][1] ? -cor_r[CORDIC_STEPS-1][1].y
                                             :  cor_r[CORDIC_STEPS-1][1].y);
    cy_nxt = MUL_W'(neg_r[CORDIC_STEPS-1][1] ? -cor_r[CORDIC_STEPS-1][1].x
                                             :  cor_r[CORDIC_STEPS-1][1].x);
  end

  // Form the four cross products in Q60
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_mul_r <= 1'b0;
    end else if (pipe_en) begin
      v_mul_r <= v_cor_r[CORDIC_STEPS-1];
    end
    if (pipe_en) begin
      sx_r   <= sx_nxt;
      cx_r   <= cx_nxt;
      sy_r   <= sy_nxt;
      cy_r   <= cy_nxt;
      p_ss_r <= sx_nxt * sy_nxt;
      p_sc_r <= sx_nxt * cy_nxt;
      p_cs_r <= cx_nxt * sy_nxt;
      p_cc_r <= cx_nxt * cy_nxt;
    end
  end

  // Round and saturate the entries other than m01; single terms are lifted to Q60 first
  always_comb begin
    out_nxt.m00 = q60_to_out(Q_W'(cy_r) <<< XY_FRAC);
    out_nxt.m01 = '0;
    out_nxt.m02 = q60_to_out(Q_W'(sy_r) <<< XY_FRAC);
    out_nxt.m10 = q60_to_out(Q_W'(p_ss_r));
    out_nxt.m11 = q60_to_out(Q_W'(cx_r) <<< XY_FRAC);
    out_nxt.m12 = q60_to_out(-Q_W'(p_sc_r));
    out_nxt.m20 = q60_to_out(-Q_W'(p_cs_r));
    out_nxt.m21 = q60_to_out(Q_W'(sx_r) <<< XY_FRAC);
    out_nxt.m22 = q60_to_out(Q_W'(p_cc_r));
  end

  // Hold the result until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= v_mul_r;
    end
    if (out_ld) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_m00   = out_r.m00;
  assign out_m01   = out_r.m01;
  assign out_m02   = out_r.m02;
  assign out_m10   = out_r.m10;
  assign out_m11   = out_r.m11;
  assign out_m12   = out_r.m12;
  assign out_m20   = out_r.m20;
  assign out_m21   = out_r.m21;
  assign out_m22   = out_r.m22;

  // Checks on the pipeline control and the angle reduction
  `ASSERT_NOW(a_stall_blocks_in, out_valid_r && !out_ready && v_mul_r, !in_ready, "input taken while pipeline is full")
  `ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v_mod_r, "accepted beat lost at reduction stage")
  `ASSERT_NOW(a_mod_range, v_mod_r, (mod_r[0] < MOD_W'(FULL_TURN_IN)) && (mod_r[1] < MOD_W'(FULL_TURN_IN)), "reduced angle out of range")
  `ASSERT_NOW(a_fold_range, v_fold_r, (fold_r[0].z <= QUARTER_Z) && (fold_r[0].z >= -QUARTER_Z) && (fold_r[1].z <= QUARTER_Z) && (fold_r[1].z >= -QUARTER_Z), "folded angle beyond a quarter turn")

endmodule

`default_nettype wire
